// ===== design/rpnp_pkg.sv =====
// ---------------------------------------------------------------------------
// rpnp_pkg: shared types and character helpers for the number parser
// Holds the mode, scan phase and position codes, the input item layout and
// small character classification functions used by the parser files.
// ---------------------------------------------------------------------------
package rpnp_pkg;

   typedef enum logic [2:0] {
      MODE_DEF = 3'd0,
      MODE_BIN = 3'd1,
      MODE_OCT = 3'd2,
      MODE_DEC = 3'd3,
      MODE_HEX = 3'd4,
      MODE_CV  = 3'd5
   } mode_type;

   // Scan phase of the default (stream-style) decimal mode.
   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_STOP   = 2'd3
   } phase_type;

   // Position within the string: nothing seen, first character held, body.
   typedef enum logic [1:0] {
      POS_START = 2'd0,
      POS_HELD  = 2'd1,
      POS_BODY  = 2'd2
   } pos_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       has_char;
      logic       last;
   } item_type;

   typedef struct packed {
      logic     fire;
      logic     ok;
      mode_type mode;
   } res_ctl_type;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_LO_C  = 8'h63;
   localparam logic [7:0] CH_LO_D  = 8'h64;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_O  = 8'h6f;
   localparam logic [7:0] CH_LO_V  = 8'h76;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [4:0] DIGIT_BAD = 5'd16;

   // Folds A..Z to lower case; every other code passes unchanged.
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_UP_A && c <= CH_UP_Z) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_dec_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Stream-style whitespace: tab through carriage return, and space.
   function automatic logic is_stream_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // Digit value of a folded character, DIGIT_BAD when it is no hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = DIGIT_BAD;
      if (is_dec_digit(c)) begin
         r = {1'b0, c[3:0]};
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         r = {1'b0, c[3:0]} + 5'd9;
      end
      return r;
   endfunction

endpackage

// ===== design/rpnp_core.sv =====
// ---------------------------------------------------------------------------
// rpnp_core: parser state and per-character datapath
// Holds the string state and computes, combinationally, the state after one
// item and the result that the item produces when it ends the string.
// ---------------------------------------------------------------------------
module rpnp_core #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  rpnp_pkg::item_type       item,
   output rpnp_pkg::res_ctl_type    res_ctl,
   output logic [VALUE_WIDTH-1:0]   res_value
);
   import rpnp_pkg::*;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] acc;
      phase_type              phase;
      logic                   neg;
   } dstate_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] acc;
      phase_type              phase;
      logic                   neg;
      logic                   failed;
      mode_type               mode;
      logic [7:0]             held;
      pos_type                pos;
   } core_state_type;

   core_state_type state_ff, state_in;

   // One character of stream-style decimal parsing.
   function automatic dstate_type feed_default(input dstate_type s, input logic [7:0] c);
      dstate_type r;
      r = s;
      if (s.phase == PH_SPACE && is_stream_space(c)) begin
         r = s;
      end else if (s.phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
         r.neg   = (c == CH_MINUS);
         r.phase = PH_SIGN;
      end else if (s.phase == PH_STOP) begin
         r = s;
      end else if (is_dec_digit(c)) begin
         r.acc   = (s.acc << 3) + (s.acc << 1) + VALUE_WIDTH'(c[3:0]);
         r.phase = PH_DIGITS;
      end else begin
         r.phase = PH_STOP;
      end
      return r;
   endfunction

   logic [7:0]             c;
   logic                   do_finish;
   logic                   empty;
   core_state_type         w;
   dstate_type             d1, d2;
   logic [4:0]             dval;
   logic                   dig_ok;
   logic [VALUE_WIDTH-1:0] shifted;

   assign c = fold_char(item.char_code);

   always_comb begin
      w         = state_ff;
      do_finish = 1'b0;
      empty     = 1'b0;
      d1        = '{acc: state_ff.acc, phase: state_ff.phase, neg: state_ff.neg};
      d2        = d1;
      dval      = hex_value(c);
      dig_ok    = 1'b0;
      shifted   = state_ff.acc;

      case (state_ff.pos)
         POS_START: begin
            if (!item.has_char) begin
               do_finish = 1'b1;
               empty     = 1'b1;
            end else begin
               w.held   = c;
               w.acc    = '0;
               w.failed = 1'b0;
               w.neg    = 1'b0;
               w.phase  = PH_SPACE;
               w.mode   = MODE_DEF;
               w.pos    = POS_HELD;
               if (item.last) begin
                  d2 = feed_default('{acc: '0, phase: PH_SPACE, neg: 1'b0}, c);
                  w.acc   = d2.acc;
                  w.phase = d2.phase;
                  w.neg   = d2.neg;
                  do_finish = 1'b1;
               end
            end
         end
         POS_HELD: begin
            if (!item.has_char) begin
               d2 = feed_default(d1, state_ff.held);
               w.mode  = MODE_DEF;
               w.acc   = d2.acc;
               w.phase = d2.phase;
               w.neg   = d2.neg;
               do_finish = 1'b1;
            end else begin
               if (state_ff.held == CH_ZERO && c == CH_LO_B) begin
                  w.mode = MODE_BIN;
               end else if (state_ff.held == CH_ZERO && c == CH_LO_O) begin
                  w.mode = MODE_OCT;
               end else if (state_ff.held == CH_ZERO && c == CH_LO_D) begin
                  w.mode = MODE_DEC;
               end else if (state_ff.held == CH_ZERO && c == CH_LO_X) begin
                  w.mode = MODE_HEX;
               end else if (state_ff.held == CH_LO_C && c == CH_LO_V) begin
                  w.mode = MODE_CV;
               end else begin
                  // No prefix: both held characters go through the decimal scan.
                  d2 = feed_default(feed_default(d1, state_ff.held), c);
                  w.mode  = MODE_DEF;
                  w.acc   = d2.acc;
                  w.phase = d2.phase;
                  w.neg   = d2.neg;
               end
               w.pos     = POS_BODY;
               do_finish = item.last;
            end
         end
         default: begin
            if (item.has_char) begin
               if (state_ff.mode == MODE_DEF) begin
                  d2 = feed_default(d1, c);
                  w.acc   = d2.acc;
                  w.phase = d2.phase;
                  w.neg   = d2.neg;
               end else if (state_ff.mode != MODE_CV && !state_ff.failed &&
                            c != CH_SPACE) begin
                  case (state_ff.mode)
                     MODE_BIN: begin
                        dig_ok  = (dval < 5'd2);
                        shifted = state_ff.acc << 1;
                     end
                     MODE_OCT: begin
                        dig_ok  = (dval < 5'd8);
                        shifted = state_ff.acc << 3;
                     end
                     MODE_DEC: begin
                        dig_ok  = (dval < 5'd10);
                        shifted = (state_ff.acc << 3) + (state_ff.acc << 1);
                     end
                     default: begin
                        dig_ok  = (dval < DIGIT_BAD);
                        shifted = state_ff.acc << 4;
                     end
                  endcase
                  if (dig_ok) begin
                     w.acc = shifted + VALUE_WIDTH'(dval[3:0]);
                  end else begin
                     w.failed = 1'b1;
                  end
               end
            end
            do_finish = !item.has_char || item.last;
         end
      endcase

      // End of string: settle the value and return to the start position.
      res_ctl.fire = do_finish;
      res_ctl.ok   = 1'b1;
      res_ctl.mode = w.mode;
      state_in     = w;
      if (do_finish) begin
         if (empty) begin
            res_ctl.ok   = 1'b0;
            res_ctl.mode = MODE_DEF;
         end else if (w.mode == MODE_CV) begin
            state_in.acc = '1;
         end else if (w.mode == MODE_DEF) begin
            if (w.neg) begin
               state_in.acc = '0 - w.acc;
            end
         end else begin
            res_ctl.ok = !w.failed;
         end
         state_in.pos    = POS_START;
         state_in.phase  = PH_SPACE;
         state_in.neg    = 1'b0;
         state_in.failed = 1'b0;
      end
      res_value = state_in.acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{acc: '0, phase: PH_SPACE, neg: 1'b0, failed: 1'b0,
                       mode: MODE_DEF, held: 8'd0, pos: POS_START};
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/radix_prefixed_number_parser.sv =====
// ---------------------------------------------------------------------------
// radix_prefixed_number_parser: ASCII integer literal parser
// Parses one string of characters, one item per character, into a value.
// ---------------------------------------------------------------------------
// The block reads a string one character per item and gives one result item
// when the string ends, either on an item with tlast set or on an item whose
// has_char flag is clear (which ends the string at once and carries no
// character). The first two characters, without regard to case, choose the
// mode: "0b", "0o", "0d" and "0x" accumulate binary, octal, decimal or hex
// digits, skip spaces and fail on any other character; "cv" returns all ones;
// any other start is read as an unsigned decimal in stream style, skipping
// leading whitespace, taking one optional sign and stopping at the first
// non-digit. Values wrap modulo 2^VALUE_WIDTH. An empty string reports ok
// clear and returns the value left by the previous string. The block takes
// one item per cycle with no bubbles, except while an item that ends a string
// waits; that item goes from the input register through the combinational
// character datapath into the result register. While that
// register holds a result the result side has not taken, an item that ends
// another string waits in the input register. A waiting result does not stop
// the block from taking items that produce no result.
// ---------------------------------------------------------------------------
module radix_prefixed_number_parser #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,  // [7:0] char_code
   input  logic                                      req_tuser,  // [0] has_char
   input  logic                                      req_tlast,  // [0] last
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0]  rsp_tdata,  // value
   output logic [3:0]                                rsp_tuser   // [0] ok, [3:1] radix_mode
);
   import rpnp_pkg::*;

   localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;

   // Input register.
   logic                   in_valid_ff;
   item_type               in_item_ff;

   // Result register.
   logic                   out_valid_ff;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic                   out_ok_ff;
   mode_type               out_mode_ff;

   res_ctl_type            res_ctl;
   logic [VALUE_WIDTH-1:0] res_value;
   logic                   out_free;
   logic                   advance;

   // The held item moves on when it produces no result or the result
   // register can take the one it produces.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!res_ctl.fire || out_free);
   assign req_tready = !in_valid_ff || advance;

   rpnp_core #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .res_ctl   (res_ctl),
      .res_value (res_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= '{char_code: req_tdata, has_char: req_tuser, last: req_tlast};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && res_ctl.fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_ctl.fire) begin
         out_value_ff <= res_value;
         out_ok_ff    <= res_ctl.ok;
         out_mode_ff  <= res_ctl.mode;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(out_value_ff);
   assign rsp_tuser  = {out_mode_ff, out_ok_ff};

endmodule

// ===== bench/parse_checker.sv =====
// ---------------------------------------------------------------------------
// parse_checker: result predictor and scoreboard for the number parser
// Watches both streams, predicts each parse from the accepted characters and
// compares every accepted result item with the oldest predicted parse.
// ---------------------------------------------------------------------------
module parse_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] has_char
   input  logic        req_tlast,   // [0] last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [63:0] value
   input  logic [3:0]  rsp_tuser,   // [0] ok, [3:1] radix_mode
   output int          mismatch_total,
   output int          pending_parses
);

   import rpnp_pkg::*;

   localparam logic [7:0] CASE_GAP = 8'd32;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [63:0] value;
      logic        ok;
      mode_type    mode;
   } parse_result_type;

   parse_result_type expected_parses[$];

   // Shadow copy of the parser state.
   logic [63:0] acc_value;
   pos_type     str_pos;
   logic [7:0]  first_char;
   mode_type    cur_mode;
   logic        digit_bad;
   logic        minus_seen;
   phase_type   scan_ph;
   int          mismatches;

   // One character of a stream-style unsigned decimal.
   function automatic void stream_char(input logic [7:0] c);
      logic is_digit;
      logic is_ws;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      if (scan_ph == PH_SPACE && is_ws) begin
         // Leading whitespace is dropped.
      end else if (scan_ph == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
         minus_seen = (c == CH_MINUS);
         scan_ph = PH_SIGN;
      end else if (scan_ph != PH_STOP) begin
         if (is_digit) begin
            acc_value = acc_value * 64'd10 + 64'(c - CH_ZERO);
            scan_ph = PH_DIGITS;
         end else begin
            scan_ph = PH_STOP;
         end
      end
   endfunction

   // One character after a radix prefix; spaces are skipped.
   function automatic void radix_char(input logic [7:0] c);
      logic [4:0] dval;
      logic [4:0] base;
      if (!digit_bad && c != CH_SPACE) begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            dval = 5'(c - CH_ZERO);
         end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            dval = 5'(c - CH_LO_A) + 5'd10;
         end else begin
            dval = DIGIT_BAD;
         end
         case (cur_mode)
            MODE_BIN: base = 5'd2;
            MODE_OCT: base = 5'd8;
            MODE_DEC: base = 5'd10;
            default:  base = 5'd16;
         endcase
         if (dval >= base) begin
            digit_bad = 1'b1;
         end else begin
            acc_value = acc_value * 64'(base) + 64'(dval);
         end
      end
   endfunction

   function automatic void close_string(input logic empty);
      parse_result_type r;
      r.mode = cur_mode;
      if (empty) begin
         r.ok = 1'b0;
         r.mode = MODE_DEF;
      end else if (cur_mode == MODE_CV) begin
         acc_value = '1;
         r.ok = 1'b1;
      end else if (cur_mode == MODE_DEF) begin
         if (minus_seen) begin
            acc_value = -acc_value;
         end
         r.ok = 1'b1;
      end else begin
         r.ok = !digit_bad;
      end
      r.value = acc_value;
      expected_parses.push_back(r);
      str_pos = POS_START;
      scan_ph = PH_SPACE;
      minus_seen = 1'b0;
      digit_bad = 1'b0;
   endfunction

   function automatic void take_char(input logic [7:0] raw, input logic has,
                                     input logic fin);
      logic [7:0] c;
      c = (raw >= CH_UP_A && raw <= CH_UP_Z) ? raw + CASE_GAP : raw;
      if (!has) begin
         // A flag-only item ends the string whatever tlast says.
         if (str_pos == POS_START) begin
            close_string(1'b1);
         end else begin
            if (str_pos == POS_HELD) begin
               cur_mode = MODE_DEF;
               stream_char(first_char);
            end
            close_string(1'b0);
         end
      end else if (str_pos == POS_START) begin
         first_char = c;
         acc_value = '0;
         digit_bad = 1'b0;
         minus_seen = 1'b0;
         scan_ph = PH_SPACE;
         cur_mode = MODE_DEF;
         str_pos = POS_HELD;
         if (fin) begin
            stream_char(first_char);
            close_string(1'b0);
         end
      end else begin
         if (str_pos == POS_HELD) begin
            if (first_char == CH_ZERO && c == CH_LO_B) begin
               cur_mode = MODE_BIN;
            end else if (first_char == CH_ZERO && c == CH_LO_O) begin
               cur_mode = MODE_OCT;
            end else if (first_char == CH_ZERO && c == CH_LO_D) begin
               cur_mode = MODE_DEC;
            end else if (first_char == CH_ZERO && c == CH_LO_X) begin
               cur_mode = MODE_HEX;
            end else if (first_char == CH_LO_C && c == CH_LO_V) begin
               cur_mode = MODE_CV;
            end else begin
               cur_mode = MODE_DEF;
               stream_char(first_char);
               stream_char(c);
            end
            str_pos = POS_BODY;
         end else if (cur_mode == MODE_DEF) begin
            stream_char(c);
         end else if (cur_mode != MODE_CV) begin
            radix_char(c);
         end
         if (fin) begin
            close_string(1'b0);
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      parse_result_type want;
      if (reset) begin
         acc_value = '0;
         str_pos = POS_START;
         first_char = '0;
         cur_mode = MODE_DEF;
         digit_bad = 1'b0;
         minus_seen = 1'b0;
         scan_ph = PH_SPACE;
         mismatches = 0;
         expected_parses.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            take_char(req_tdata, req_tuser, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_parses.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("result with no parse pending: value %h ok %b mode %0d",
                           rsp_tdata, rsp_tuser[0], rsp_tuser[3:1]);
               end
            end else begin
               want = expected_parses.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser[0] !== want.ok ||
                   rsp_tuser[3:1] !== want.mode) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("parse mismatch: value exp %h got %h, ok exp %b got %b,",
                              want.value, rsp_tdata, want.ok, rsp_tuser[0]);
                     $display("   mode exp %0d got %0d", want.mode, rsp_tuser[3:1]);
                  end
               end
            end
         end
      end
      mismatch_total <= mismatches;
      pending_parses <= expected_parses.size();
   end

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the radix prefixed number parser
// Sends directed and random character strings in bursts while the result
// side stalls on changing patterns; a separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;

   import rpnp_pkg::*;

   localparam logic [7:0] CASE_GAP = 8'd32;
   // Stop sending random strings once this many items have been accepted.
   localparam int ITEM_TARGET = 1380;
   // Cycles without any accepted item, on either side, before giving up.
   localparam int QUIET_LIMIT = 4000;
   // Cycles to let pass after the last result.
   localparam int SETTLE_CYCLES = 10;

   // Styles of the result-side stall pattern.
   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_PATTERN,
      RX_CHOKED
   } rx_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [7:0] char_code
   logic        req_tuser = 1'b0;   // [0] has_char
   logic        req_tlast = 1'b0;   // [0] last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // [63:0] value
   logic [3:0]  rsp_tuser;          // [0] ok, [3:1] radix_mode

   int mismatch_total;
   int pending_parses;

   // Sender bookkeeping. The sender works in bursts; steady turns the gaps
   // between bursts off for a while so that back-to-back stretches occur.
   int sent_items = 0;
   int burst_left = 4;
   bit steady = 1'b0;

   // Characters of the string that is about to be sent.
   logic [7:0] text_buf[$];

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   radix_prefixed_number_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   parse_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_total (mismatch_total),
      .pending_parses (pending_parses)
   );

   // The result side picks a new stall style when its random hold count runs out: always
   // ready, a coin toss per cycle, a fixed three-in-seven pattern, or mostly
   // stalled. The pattern keeps running while the sender is quiet, so stalls
   // land on every phase of the parser's work.
   rx_style_type stall_style = RX_OPEN;
   int           style_left = 0;
   int           tick = 0;

   always @(posedge clock) begin
      tick <= tick + 1;
      if (style_left == 0) begin
         stall_style <= rx_style_type'($urandom_range(0, 3));
         style_left <= $urandom_range(50, 400);
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         RX_OPEN:    rsp_tready <= 1'b1;
         RX_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         RX_PATTERN: rsp_tready <= ((tick % 7) >= 4);
         default:    rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Watchdog: a healthy run never goes this long without moving an item on
   // one side or the other.
   int quiet = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet <= 0;
         end else begin
            quiet <= quiet + 1;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Offers one item and holds it until the parser takes it. The valid stays
   // high afterwards unless the burst ends, so back-to-back items never see
   // the valid dropped and raised in the same step.
   task automatic send_item(input logic [7:0] c, input logic has, input logic fin);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= has;
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent_items++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Sends the buffered string. It ends either with tlast on its final
   // character or, when end_by_flag is set, with a trailing item that has no
   // character; that item carries a random code and a random tlast, which the
   // parser must ignore. An empty buffer always gives a flag-only item.
   task automatic send_text(input bit end_by_flag);
      int i;
      for (i = 0; i < text_buf.size(); i++) begin
         send_item(text_buf[i], 1'b1, !end_by_flag && (i == text_buf.size() - 1));
      end
      if (end_by_flag || text_buf.size() == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
      text_buf.delete();
   endtask

   task automatic load_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
   endtask

   // Stops sending and waits until every predicted parse has come out.
   task automatic drain_parser();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_parses != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int         kind;
      int         n;
      int         i;
      int         dv;
      int         top_digit;
      bit         mid_drained;
      logic [7:0] letter;
      logic [7:0] c;

      mid_drained = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings. First an empty string straight after reset, which
      // must report the zero accumulator with ok clear.
      send_text(1'b1);
      // Each prefix with mixed case; the binary one has a space to skip.
      load_text("0B 1");
      send_text(1'b0);
      load_text("0o7");
      send_text(1'b0);
      load_text("0d9");
      send_text(1'b0);
      load_text("0xF");
      send_text(1'b0);
      load_text("cV");
      send_text(1'b0);
      // Default mode: leading space, minus sign, stop at the first letter.
      load_text(" -1a");
      send_text(1'b0);
      // A digit that is out of range for the radix fails the string.
      load_text("0b2");
      send_text(1'b0);
      // One held character closed by a flag-only item, then an empty string
      // that has to repeat the value left behind.
      load_text("7");
      send_text(1'b1);
      send_text(1'b1);
      // The extreme character codes, each as a one-character string.
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      drain_parser();

      // Random strings. Most are well formed with random content, so that the
      // prefixed and stream-style paths get deep; the rest is noise and
      // empty strings. A few long digit runs make the value wrap.
      while (sent_items < ITEM_TARGET) begin
         if (sent_items >= ITEM_TARGET / 2 && !mid_drained) begin
            drain_parser();
            mid_drained = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            case ($urandom_range(0, 3))
               0: begin
                  letter = CH_LO_B;
                  top_digit = 1;
               end
               1: begin
                  letter = CH_LO_O;
                  top_digit = 7;
               end
               2: begin
                  letter = CH_LO_D;
                  top_digit = 9;
               end
               default: begin
                  letter = CH_LO_X;
                  top_digit = 15;
               end
            endcase
            text_buf.push_back(CH_ZERO);
            text_buf.push_back($urandom_range(0, 1) ? letter - CASE_GAP : letter);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 8);
            for (i = 0; i < n; i++) begin
               dv = $urandom_range(0, 99);
               if (dv < 8) begin
                  c = CH_SPACE;
               end else if (dv < 14) begin
                  c = 8'($urandom_range(0, 255));
               end else begin
                  dv = $urandom_range(0, top_digit);
                  if (dv < 10) begin
                     c = CH_ZERO + 8'(dv);
                  end else begin
                     c = ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(dv - 10);
                  end
               end
               text_buf.push_back(c);
            end
         end else if (kind < 55) begin
            // The all-ones literal; whatever follows it is ignored.
            text_buf.push_back($urandom_range(0, 1) ? CH_LO_C - CASE_GAP : CH_LO_C);
            text_buf.push_back($urandom_range(0, 1) ? CH_LO_V - CASE_GAP : CH_LO_V);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
               text_buf.push_back(8'($urandom_range(0, 255)));
            end
         end else if (kind < 85) begin
            // Stream-style decimal: whitespace, an optional sign, digits and
            // sometimes trailing junk.
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++) begin
               c = CH_TAB + 8'($urandom_range(0, 5));
               text_buf.push_back((c > CH_CR) ? CH_SPACE : c);
            end
            if ($urandom_range(0, 1)) begin
               text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 6);
            for (i = 0; i < n; i++) begin
               text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 9) < 3) begin
               n = $urandom_range(1, 3);
               for (i = 0; i < n; i++) begin
                  text_buf.push_back(8'($urandom_range(0, 255)));
               end
            end
         end else if (kind < 95) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
               text_buf.push_back(8'($urandom_range(0, 255)));
            end
         end
         // Anything from 95 up leaves the buffer empty: an empty string.
         send_text(kind >= 95 || $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 15) == 0) begin
            steady = !steady;
         end
      end

      drain_parser();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && pending_parses == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
